// File: rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, codes and defaults for the TTL session cache: request and
// response beats, controller states, and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package tsc_pkg;

    // Default geometry and register reset
    localparam int          TSC_ENTRIES     = 16;
    localparam int          TSC_KEY_BYTES   = 32;
    localparam logic [31:0] TSC_DEFAULT_TTL = 32'(10 * 60);

    // Request codes
    localparam logic [2:0] REQ_ADD     = 3'd0;
    localparam logic [2:0] REQ_LOOKUP  = 3'd1;
    localparam logic [2:0] REQ_DELETE  = 3'd2;
    localparam logic [2:0] REQ_CLEANUP = 3'd3;
    localparam logic [2:0] REQ_TICK    = 3'd4;

    // Response status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Request beat
    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [5:0]  key_len;
        logic [63:0] data_handle;
        logic [31:0] ttl_seconds;
    } t_req;

    // Response beat
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] read_handle;
        logic        entries_remain;
    } t_rsp;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // capture the request beat, rewind the scan
        logic scan_step;  // read the entry at the scan pointer
        logic finish;     // apply the update, load the response register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;  // held request walks the table
        logic scan_last;  // scan pointer sits on the last entry
        logic out_busy;   // response register cannot take a beat
    } t_stat;

endpackage

// File: rtl/tsc_ctrl.sv
// ----------------------------------------------------------------------------
// tsc_ctrl
// Request sequencer: accepts one request, has the datapath walk the table
// if needed, then commits the result once the response register is free.
// ----------------------------------------------------------------------------
module tsc_ctrl
    import tsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_stat.need_scan) begin
                    n_state = S_FIN;
                end else if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Drive commands
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.finish    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan_step = i_stat.need_scan;
            end
            S_DRAIN: begin
            end
            S_FIN: begin
                o_cmd.finish = !i_stat.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/tsc_datapath.sv
// ----------------------------------------------------------------------------
// tsc_datapath
// Entry memories, valid bits, seconds clock and default ttl register. Reads
// one entry a cycle under the controller, tracks the first key match and the
// lowest free slot, and commits the update and response at finish.
// ----------------------------------------------------------------------------
module tsc_datapath
    import tsc_pkg::*;
#(
    parameter int ENTRIES   = TSC_ENTRIES,
    parameter int KEY_BYTES = TSC_KEY_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  t_req        i_in_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KW = KEY_BYTES * 8;

    // Keep only the bytes inside the key length
    function automatic logic [KW-1:0] mask_key(input t_req req);
        logic [255:0]  words;
        logic [KW-1:0] res;
        words = {req.key_word3, req.key_word2, req.key_word1, req.key_word0};
        for (int b = 0; b < KEY_BYTES; b++) begin
            res[b*8 +: 8] = (b < int'(req.key_len)) ? words[b*8 +: 8] : 8'h00;
        end
        return res;
    endfunction

    // Entry memories
    logic [KW-1:0] mem_key    [ENTRIES];
    logic [5:0]    mem_len    [ENTRIES];
    logic [63:0]   mem_handle [ENTRIES];
    logic [32:0]   mem_exp    [ENTRIES];

    t_req          r_req;
    logic [KW-1:0] r_key_m;
    logic [31:0]   r_default_ttl;
    logic [31:0]   r_time;
    logic [31:0]   n_time;
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] n_valid;
    logic [IW-1:0] r_idx;

    logic          r_cmp_en;
    logic [IW-1:0] r_cmp_idx;
    logic [KW-1:0] r_rd_key;
    logic [5:0]    r_rd_len;
    logic [63:0]   r_rd_handle;
    logic [32:0]   r_rd_exp;

    logic          r_hit_found;
    logic [IW-1:0] r_hit_idx;
    logic [63:0]   r_hit_handle;
    logic          r_hit_stale;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic          r_remain;

    logic          r_out_valid;
    t_rsp          r_out_data;
    t_rsp          n_rsp;

    logic          c_valid;
    logic          c_stale;
    logic          c_match;
    logic          is_cleanup;
    logic [31:0]   ttl_eff;
    logic [32:0]   exp_new;
    logic          w_handle_we;
    logic          w_new_we;
    logic [IW-1:0] w_addr;

    // Status to the controller
    assign o_stat.need_scan = (r_req.req_type == REQ_ADD)    ||
                              (r_req.req_type == REQ_LOOKUP) ||
                              (r_req.req_type == REQ_DELETE) ||
                              (r_req.req_type == REQ_CLEANUP);
    assign o_stat.scan_last = (r_idx == IW'(ENTRIES - 1));
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign is_cleanup  = (r_req.req_type == REQ_CLEANUP);

    // Capture the request beat with its key already masked
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= i_in_data;
            r_key_m <= mask_key(i_in_data);
        end
    end

    // Hold the default ttl register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_ttl <= TSC_DEFAULT_TTL;
        end else if (i_cfg_valid) begin
            r_default_ttl <= i_cfg_data;
        end
    end

    // Advance the scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.accept) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step && !o_stat.scan_last) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // Read one entry per scan step
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd_key    <= mem_key[r_idx];
            r_rd_len    <= mem_len[r_idx];
            r_rd_handle <= mem_handle[r_idx];
            r_rd_exp    <= mem_exp[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_en <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.scan_step;
        end
        r_cmp_idx <= r_idx;
    end

    // Compare the entry just read
    assign c_valid = r_cmp_en && r_valid[r_cmp_idx];
    assign c_stale = {1'b0, r_time} > r_rd_exp;
    assign c_match = c_valid && (r_req.key_len != 6'd0) &&
                     (r_rd_len == r_req.key_len) && (r_rd_key == r_key_m);

    // Track first match, lowest free slot and live entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.accept) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_remain     <= 1'b0;
        end else if (r_cmp_en) begin
            if (c_match && !r_hit_found) begin
                r_hit_found  <= 1'b1;
                r_hit_idx    <= r_cmp_idx;
                r_hit_handle <= r_rd_handle;
                r_hit_stale  <= c_stale;
            end
            if (!r_valid[r_cmp_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
            if (is_cleanup && c_valid && !c_stale) begin
                r_remain <= 1'b1;
            end
        end
    end

    // Lifetime of a new entry
    assign ttl_eff = (r_req.ttl_seconds != 32'd0) ? r_req.ttl_seconds : r_default_ttl;
    assign exp_new = {1'b0, r_time} + {1'b0, ttl_eff};

    // Work out the update and the response
    always_comb begin
        n_valid     = r_valid;
        n_time      = r_time;
        n_rsp       = '0;
        w_handle_we = 1'b0;
        w_new_we    = 1'b0;
        w_addr      = r_hit_idx;
        // drop stale entries as the cleanup scan passes them
        if (is_cleanup && c_valid && c_stale) begin
            n_valid[r_cmp_idx] = 1'b0;
        end
        if (i_cmd.finish) begin
            case (r_req.req_type)
                REQ_ADD: begin
                    if (r_hit_found) begin
                        w_handle_we = 1'b1;
                    end else if (r_free_found) begin
                        w_addr              = r_free_idx;
                        w_handle_we         = 1'b1;
                        w_new_we            = 1'b1;
                        n_valid[r_free_idx] = 1'b1;
                    end else begin
                        n_rsp.status = ST_FULL;
                    end
                end
                REQ_LOOKUP: begin
                    if (!r_hit_found) begin
                        n_rsp.status = ST_NOT_FOUND;
                    end else if (r_hit_stale) begin
                        n_valid[r_hit_idx] = 1'b0;
                        n_rsp.status       = ST_NOT_FOUND;
                    end else begin
                        n_rsp.read_handle = r_hit_handle;
                    end
                end
                REQ_DELETE: begin
                    if (r_hit_found) begin
                        n_valid[r_hit_idx] = 1'b0;
                    end
                end
                REQ_CLEANUP: begin
                    n_rsp.entries_remain = r_remain;
                end
                REQ_TICK: begin
                    n_time = r_time + 32'd1;
                end
                default: begin
                end
            endcase
        end
    end

    // Write the entry memories
    always_ff @(posedge i_clk) begin
        if (w_handle_we) begin
            mem_handle[w_addr] <= r_req.data_handle;
        end
        if (w_new_we) begin
            mem_key[w_addr] <= r_key_m;
            mem_len[w_addr] <= r_req.key_len;
            mem_exp[w_addr] <= exp_new;
        end
    end

    // Hold valid bits and the seconds clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_time  <= '0;
        end else begin
            r_valid <= n_valid;
            r_time  <= n_time;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_out_data <= n_rsp;
        end
    end

endmodule

// File: rtl/ttl_session_cache.sv
// ----------------------------------------------------------------------------
// ttl_session_cache
// Keyed session table with expiry. Each request beat (add, lookup, delete,
// cleanup, tick) gives exactly one response beat. Add, lookup, delete and
// cleanup walk the whole table one entry per cycle through a single read
// port on the entry memories: such a request is accepted, reads each entry
// in turn, compares the last entry read, and then commits. Tick and unknown
// codes skip the scan and go from accept to commit. A finished response
// waits in an output register; the next request is taken once the current
// one has committed, and a commit waits while the previous response is
// still held. Valid bits clear at reset with no clearing pass, and the
// default ttl register resets to 600 seconds.
// ----------------------------------------------------------------------------
module ttl_session_cache
    import tsc_pkg::*;
#(
    parameter int ENTRIES   = TSC_ENTRIES,
    parameter int KEY_BYTES = TSC_KEY_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // Sequence requests
    tsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Store and scan entries
    tsc_datapath #(
        .ENTRIES   (ENTRIES),
        .KEY_BYTES (KEY_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    // One request at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // Commit only when the response register can take the beat
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!o_out_valid || i_out_ready))
        else $error("commit overwrote a pending response");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK ||
                         o_out_data.status == ST_NOT_FOUND ||
                         o_out_data.status == ST_FULL))
        else $error("undefined status code");

    // A failed request carries no handle
    a_fail_no_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> (o_out_data.read_handle == '0))
        else $error("handle returned with failing status");
`endif

endmodule

// File: dv/tb_ttl_session_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ttl_session_cache
// Self-checking bench for the TTL session cache. A behavioral copy of the
// table (keys, lengths, handles, expiry, seconds clock, default ttl) predicts
// one response per accepted request. Each response beat is compared field by
// field against the oldest prediction. Directed tests cover key matching,
// expiry, the full table and unknown codes. Randomized phases then drive
// mixed traffic over a small key pool at several default ttl settings, with
// bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb_ttl_session_cache;
    import tsc_pkg::*;

    localparam int         N_SLOTS     = TSC_ENTRIES;
    localparam int         POOL_KEYS   = 20;
    localparam int         CYCLE_LIMIT = 500000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_req        in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_rsp        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    // Behavioral copy of the table
    bit           slot_live   [N_SLOTS];
    logic [255:0] slot_key    [N_SLOTS];
    logic [5:0]   slot_len    [N_SLOTS];
    logic [63:0]  slot_handle [N_SLOTS];
    logic [32:0]  slot_expiry [N_SLOTS];
    logic [31:0]  clock_secs  = '0;
    logic [31:0]  ttl_default = TSC_DEFAULT_TTL;

    t_rsp rsp_due[$];
    int   mismatch_count = 0;
    int   burst_left     = 0;
    int   ready_run      = 0;
    int   cycle_count    = 0;

    ttl_session_cache dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // Clock
    initial begin
        forever #2 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d responses outstanding", $time, rsp_due.size());
            $display("tb_ttl_session_cache: FAIL");
            $finish;
        end
    end

    // Stall the response side: long open runs, hard stalls, random cycles
    always @(posedge clk) begin
        if (ready_run > 0) begin
            ready_run <= ready_run - 1;
        end else begin
            case ($urandom_range(0, 7))
                0: begin
                    out_ready <= 1'b0;
                    ready_run <= $urandom_range(4, 14);
                end
                1, 2: begin
                    out_ready <= 1'b1;
                    ready_run <= $urandom_range(40, 160);
                end
                default: begin
                    out_ready <= 1'($urandom_range(0, 1));
                    ready_run <= 0;
                end
            endcase
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [255:0] rand_key();
        return {rand64(), rand64(), rand64(), rand64()};
    endfunction

    // Bytes of the key that take part in a compare
    function automatic logic [255:0] key_mask(input logic [5:0] len);
        int n;
        n = (len > TSC_KEY_BYTES) ? TSC_KEY_BYTES : int'(len);
        if (n * 8 >= 256)
            return {256{1'b1}};
        return (256'd1 << (8 * n)) - 256'd1;
    endfunction

    function automatic int find_slot(input logic [255:0] key, input logic [5:0] len);
        logic [255:0] m;
        int s;
        m = key_mask(len);
        for (s = 0; s < N_SLOTS; s++) begin
            if (slot_live[s] && len != 0 && slot_len[s] == len &&
                (slot_key[s] & m) == (key & m))
                return s;
        end
        return -1;
    endfunction

    function automatic bit slot_stale(input int s);
        return {1'b0, clock_secs} > slot_expiry[s];
    endfunction

    // Apply one request to the table copy and return its response
    function automatic t_rsp cache_predict(input t_req r);
        t_rsp         rsp;
        logic [255:0] key;
        int           s;
        int           free_s;
        rsp = '0;
        key = {r.key_word3, r.key_word2, r.key_word1, r.key_word0};
        case (r.req_type)
            REQ_ADD: begin
                s = find_slot(key, r.key_len);
                if (s >= 0) begin
                    // hit keeps the old expiry, stale or not
                    slot_handle[s] = r.data_handle;
                end else begin
                    free_s = -1;
                    for (s = N_SLOTS - 1; s >= 0; s--)
                        if (!slot_live[s])
                            free_s = s;
                    if (free_s < 0) begin
                        rsp.status = ST_FULL;
                    end else begin
                        slot_live[free_s]   = 1'b1;
                        slot_key[free_s]    = key & key_mask(r.key_len);
                        slot_len[free_s]    = r.key_len;
                        slot_handle[free_s] = r.data_handle;
                        slot_expiry[free_s] = 33'(clock_secs) +
                            33'((r.ttl_seconds != 0) ? r.ttl_seconds : ttl_default);
                    end
                end
            end
            REQ_LOOKUP: begin
                s = find_slot(key, r.key_len);
                if (s < 0) begin
                    rsp.status = ST_NOT_FOUND;
                end else if (slot_stale(s)) begin
                    slot_live[s] = 1'b0;
                    rsp.status   = ST_NOT_FOUND;
                end else begin
                    rsp.read_handle = slot_handle[s];
                end
            end
            REQ_DELETE: begin
                s = find_slot(key, r.key_len);
                if (s >= 0)
                    slot_live[s] = 1'b0;
            end
            REQ_CLEANUP: begin
                for (s = 0; s < N_SLOTS; s++) begin
                    if (slot_live[s]) begin
                        if (slot_stale(s))
                            slot_live[s] = 1'b0;
                        else
                            rsp.entries_remain = 1'b1;
                    end
                end
            end
            REQ_TICK: begin
                clock_secs = clock_secs + 32'd1;
            end
            default: begin
                // unknown codes answer all zero
            end
        endcase
        return rsp;
    endfunction

    function automatic t_req make_req(input logic [2:0] kind, input logic [255:0] key,
                                      input logic [5:0] len, input logic [63:0] handle,
                                      input logic [31:0] ttl);
        t_req r;
        r.req_type    = kind;
        r.key_word0   = key[63:0];
        r.key_word1   = key[127:64];
        r.key_word2   = key[191:128];
        r.key_word3   = key[255:192];
        r.key_len     = len;
        r.data_handle = handle;
        r.ttl_seconds = ttl;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch: expected %h actual %h", $time, what, want, got);
    endtask

    // Check each response beat against the oldest prediction
    always @(posedge clk) begin : rsp_check
        t_rsp want;
        if (rst_n && out_valid && out_ready) begin
            if (rsp_due.size() == 0) begin
                report_mismatch("unexpected response", 64'd0, out_data.read_handle);
            end else begin
                want = rsp_due.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", 64'(want.status), 64'(out_data.status));
                if (out_data.read_handle !== want.read_handle)
                    report_mismatch("read_handle", want.read_handle, out_data.read_handle);
                if (out_data.entries_remain !== want.entries_remain)
                    report_mismatch("entries_remain", 64'(want.entries_remain),
                                    64'(out_data.entries_remain));
            end
        end
    end

    // Send one request beat, in bursts with random gaps; predict on accept
    task automatic issue_req(input t_req req);
        int gap;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        rsp_due.push_back(cache_predict(req));
    endtask

    // Drop valid and hold until every predicted response has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (rsp_due.size() != 0);
    endtask

    task automatic write_default_ttl(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ttl_default = value;
    endtask

    // Hit, miss on length, ignored tail bytes, replace, delete twice
    task automatic test_lookup_delete();
        logic [255:0] ka;
        ka = rand_key();
        issue_req(make_req(REQ_ADD, ka, 6'd5, rand64(), 32'd0));
        issue_req(make_req(REQ_LOOKUP, ka, 6'd5, rand64(), 32'd0));
        issue_req(make_req(REQ_LOOKUP, ka ^ ~key_mask(6'd5), 6'd5, '0, 32'd0));
        issue_req(make_req(REQ_LOOKUP, ka, 6'd6, '0, 32'd0));
        issue_req(make_req(REQ_ADD, ka, 6'd5, rand64(), 32'd7));
        issue_req(make_req(REQ_LOOKUP, ka, 6'd5, '0, 32'd0));
        issue_req(make_req(REQ_DELETE, ka, 6'd5, '0, 32'd0));
        issue_req(make_req(REQ_DELETE, ka, 6'd5, '0, 32'd0));
        issue_req(make_req(REQ_LOOKUP, ka, 6'd5, '0, 32'd0));
    endtask

    // Zero-length keys, over-long length with all ones, unknown codes
    task automatic test_key_edges();
        int k;
        issue_req(make_req(REQ_ADD, '0, 6'd0, '0, 32'd0));
        issue_req(make_req(REQ_ADD, '0, 6'd0, rand64(), 32'd0));
        issue_req(make_req(REQ_LOOKUP, '0, 6'd0, '0, 32'd0));
        issue_req(make_req(REQ_ADD, '1, 6'h3F, '1, 32'hFFFF_FFFF));
        issue_req(make_req(REQ_LOOKUP, '1, 6'h3F, '0, 32'd0));
        issue_req(make_req(REQ_LOOKUP, '1, 6'd32, '0, 32'd0));
        for (k = 1; k <= 3; k++)
            issue_req(make_req(REQ_TICK + 3'(k), rand_key(), 6'($urandom_range(0, 63)),
                               rand64(), $urandom));
        issue_req(make_req(REQ_DELETE, '1, 6'h3F, '0, 32'd0));
    endtask

    // Expiry with zero and maximum default ttl, add on a stale hit, cleanup
    task automatic test_expiry();
        logic [255:0] kb;
        logic [255:0] kc;
        kb = rand_key();
        kc = rand_key();
        wait_drained();
        write_default_ttl(32'd0);
        issue_req(make_req(REQ_ADD, kb, 6'd32, rand64(), 32'd0));
        issue_req(make_req(REQ_CLEANUP, '0, 6'd0, '0, 32'd0));
        issue_req(make_req(REQ_TICK, '0, 6'd0, '0, 32'd0));
        issue_req(make_req(REQ_ADD, kb, 6'd32, rand64(), 32'd50));
        issue_req(make_req(REQ_LOOKUP, kb, 6'd32, '0, 32'd0));
        issue_req(make_req(REQ_LOOKUP, kb, 6'd32, '0, 32'd0));
        issue_req(make_req(REQ_ADD, kc, 6'd17, rand64(), 32'd1));
        issue_req(make_req(REQ_TICK, '0, 6'd0, '0, 32'd0));
        issue_req(make_req(REQ_TICK, '0, 6'd0, '0, 32'd0));
        issue_req(make_req(REQ_CLEANUP, '0, 6'd0, '0, 32'd0));
        wait_drained();
        write_default_ttl(32'hFFFF_FFFF);
        issue_req(make_req(REQ_ADD, kc, 6'd9, rand64(), 32'd0));
        issue_req(make_req(REQ_TICK, '0, 6'd0, '0, 32'd0));
        issue_req(make_req(REQ_LOOKUP, kc, 6'd9, '0, 32'd0));
        issue_req(make_req(REQ_DELETE, kc, 6'd9, '0, 32'd0));
    endtask

    // Fill the table until add reports full, then free what was stored
    task automatic test_table_full();
        logic [255:0] fill_key [N_SLOTS + 2];
        int           n_fill;
        int           k;
        n_fill = 0;
        wait_drained();
        for (k = 0; k < N_SLOTS + 2; k++) begin
            fill_key[k] = rand_key();
            issue_req(make_req(REQ_ADD, fill_key[k], 6'd8, rand64(), 32'd100));
            n_fill++;
            if (rsp_due[$].status == ST_FULL)
                break;
        end
        issue_req(make_req(REQ_ADD, rand_key(), 6'd3, rand64(), 32'd0));
        issue_req(make_req(REQ_LOOKUP, fill_key[0], 6'd8, '0, 32'd0));
        for (k = 0; k < n_fill; k++)
            issue_req(make_req(REQ_DELETE, fill_key[k], 6'd8, '0, 32'd0));
    endtask

    // Mixed traffic over a small key pool so hits, stale entries and a full
    // table all come up; a tenth of the keys are fresh noise
    task automatic run_mixed_traffic(input int n_items);
        logic [255:0] pool_key [POOL_KEYS];
        logic [5:0]   pool_len [POOL_KEYS];
        logic [255:0] key;
        logic [5:0]   len;
        logic [2:0]   kind;
        logic [31:0]  ttl;
        int           k;
        int           pick;
        int           roll;
        for (k = 0; k < POOL_KEYS; k++) begin
            case ($urandom_range(0, 9))
                0: pool_len[k] = 6'd1;
                1: pool_len[k] = 6'd8;
                2: pool_len[k] = 6'd9;
                3: pool_len[k] = 6'd16;
                4: pool_len[k] = 6'd31;
                5: pool_len[k] = 6'd32;
                6: pool_len[k] = 6'd33;
                7: pool_len[k] = 6'h3F;
                default: pool_len[k] = 6'($urandom_range(1, 63));
            endcase
            pool_key[k] = rand_key() & key_mask(pool_len[k]);
        end
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) == 0)
                wait_drained();
            pick = $urandom_range(0, POOL_KEYS - 1);
            key  = pool_key[pick];
            len  = pool_len[pick];
            if ($urandom_range(0, 1) == 0)
                key = key | (rand_key() & ~key_mask(len));
            if ($urandom_range(0, 9) == 0) begin
                key = rand_key();
                len = 6'($urandom_range(0, 63));
            end
            roll = $urandom_range(0, 99);
            if (roll < 30)
                kind = REQ_ADD;
            else if (roll < 55)
                kind = REQ_LOOKUP;
            else if (roll < 67)
                kind = REQ_DELETE;
            else if (roll < 74)
                kind = REQ_CLEANUP;
            else if (roll < 97)
                kind = REQ_TICK;
            else
                kind = REQ_TICK + 3'($urandom_range(1, 3));
            roll = $urandom_range(0, 9);
            if (roll < 4)
                ttl = 32'd0;
            else if (roll < 8)
                ttl = 32'($urandom_range(1, 12));
            else if (roll < 9)
                ttl = 32'($urandom_range(13, 200));
            else
                ttl = $urandom;
            issue_req(make_req(kind, key, len, rand64(), ttl));
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_lookup_delete();
        test_key_edges();
        test_expiry();
        test_table_full();
        wait_drained();
        write_default_ttl(32'd3);
        run_mixed_traffic(330);
        wait_drained();
        write_default_ttl(32'd0);
        run_mixed_traffic(280);
        wait_drained();
        write_default_ttl(32'($urandom_range(1, 40)));
        run_mixed_traffic(330);
        wait_drained();
        write_default_ttl(32'hFFFF_FFFF);
        run_mixed_traffic(150);
        wait_drained();
        write_default_ttl($urandom);
        run_mixed_traffic(260);
        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_ttl_session_cache: PASS");
        else
            $display("tb_ttl_session_cache: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/tsc_pkg.sv
rtl/tsc_ctrl.sv
rtl/tsc_datapath.sv
rtl/ttl_session_cache.sv
dv/tb_ttl_session_cache.sv
